>>> rtl/wsd_pkg.sv
// shared types, codes and defaults of the work-steal task deque
package wsd_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    REQ_PUSH_TAIL = 2'd0,
    REQ_PUSH_HEAD = 2'd1,
    REQ_POP_HEAD  = 2'd2,
    REQ_STEAL     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_POP_CHK,
    S_STEAL_RD,
    S_STEAL_CHK
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic push;
    logic pop_rd;
    logic pop_fin;
    logic empty_fin;
    logic steal_start;
    logic steal_rd;
    logic steal_chk;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic occ_zero;
    req_e req;
    logic hit;
    logic scan_last;
  } sts_t;

endpackage

>>> rtl/wsd_ram.sv
// generic single-port ram with registered read
module wsd_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wsd_ctrl.sv
// controller state machine sequencing deque operations
module wsd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  wsd_pkg::sts_t sts_i,
  output wsd_pkg::cmd_t cmd_o
);

  wsd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsd_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      wsd_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = wsd_pkg::S_IDLE;
        end
      end
      wsd_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = wsd_pkg::S_EXEC;
        end
      end
      wsd_pkg::S_EXEC: begin
        unique case (sts_i.req)
          wsd_pkg::REQ_PUSH_TAIL, wsd_pkg::REQ_PUSH_HEAD: begin
            cmd_o.push = 1'b1;
            state_d    = wsd_pkg::S_IDLE;
          end
          wsd_pkg::REQ_POP_HEAD: begin
            if (sts_i.occ_zero) begin
              cmd_o.empty_fin = 1'b1;
              state_d         = wsd_pkg::S_IDLE;
            end else begin
              cmd_o.pop_rd = 1'b1;
              state_d      = wsd_pkg::S_POP_CHK;
            end
          end
          wsd_pkg::REQ_STEAL: begin
            if (sts_i.occ_zero) begin
              cmd_o.empty_fin = 1'b1;
              state_d         = wsd_pkg::S_IDLE;
            end else begin
              cmd_o.steal_start = 1'b1;
              state_d           = wsd_pkg::S_STEAL_RD;
            end
          end
          default: state_d = wsd_pkg::S_IDLE;
        endcase
      end
      wsd_pkg::S_POP_CHK: begin
        cmd_o.pop_fin = 1'b1;
        state_d       = wsd_pkg::S_IDLE;
      end
      wsd_pkg::S_STEAL_RD: begin
        cmd_o.steal_rd = 1'b1;
        state_d        = wsd_pkg::S_STEAL_CHK;
      end
      wsd_pkg::S_STEAL_CHK: begin
        cmd_o.steal_chk = 1'b1;
        if (sts_i.hit || sts_i.scan_last) begin
          state_d = wsd_pkg::S_IDLE;
        end else begin
          state_d = wsd_pkg::S_STEAL_RD;
        end
      end
      default: state_d = wsd_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_q != wsd_pkg::S_IDLE);

endmodule

>>> rtl/wsd_dp.sv
// datapath: slot ram, head and tail pointers, occupancy, scan and result registers
module wsd_dp #(
  parameter int unsigned DEPTH       = wsd_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = wsd_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wsd_pkg::cmd_t                  cmd_i,
  output wsd_pkg::sts_t                  sts_o,
  input  logic [1:0]                     req_type_i,
  input  logic [HANDLE_BITS-1:0]         task_handle_i,
  input  logic                           task_unstealable_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [HANDLE_BITS-1:0]         out_handle_o,
  output logic [$clog2(DEPTH+1)-1:0]     occupancy_o,
  output logic                           notify_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned DW = HANDLE_BITS + 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, scan_q, scan_d, clr_q, clr_d;
  logic [OW-1:0] occ_q, occ_d, k_q, k_d;
  wsd_pkg::req_e req_q, req_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d, ohdl_q, ohdl_d;
  logic unst_q, unst_d, nen_q, nen_d, done_q, done_d, notify_q, notify_d;
  wsd_pkg::status_e status_q, status_d;

  logic          ram_we;
  logic [PW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic [HANDLE_BITS-1:0] rd_hdl;
  logic rd_unst, hit, full;
  logic [PW-1:0] head_m1, head_p1, tail_m1, tail_p1, scan_m1;

  wsd_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_hdl  = ram_rdata[HANDLE_BITS-1:0];
  assign rd_unst = ram_rdata[HANDLE_BITS];
  assign hit     = (rd_hdl != '0) && !rd_unst;
  assign full    = (occ_q == OW'(DEPTH));

  // ring index wrap over depth
  assign head_m1 = (head_q == '0)   ? LAST : head_q - 1'b1;
  assign head_p1 = (head_q == LAST) ? '0   : head_q + 1'b1;
  assign tail_m1 = (tail_q == '0)   ? LAST : tail_q - 1'b1;
  assign tail_p1 = (tail_q == LAST) ? '0   : tail_q + 1'b1;
  assign scan_m1 = (scan_q == '0)   ? LAST : scan_q - 1'b1;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    scan_d    = scan_q;
    clr_d     = clr_q;
    occ_d     = occ_q;
    k_d       = k_q;
    req_d     = req_q;
    hdl_d     = hdl_q;
    unst_d    = unst_q;
    nen_d     = cfg_we_i ? cfg_wdata_i : nen_q;
    done_d    = 1'b0;
    status_d  = status_q;
    ohdl_d    = ohdl_q;
    notify_d  = notify_q;
    ram_we    = 1'b0;
    ram_addr  = head_q;
    ram_wdata = '0;

    if (cmd_i.clr_wr) begin
      ram_we   = 1'b1;
      ram_addr = clr_q;
      clr_d    = clr_q + 1'b1;
    end

    if (cmd_i.capture) begin
      req_d  = wsd_pkg::req_e'(req_type_i);
      hdl_d  = task_handle_i;
      unst_d = task_unstealable_i;
    end

    if (cmd_i.push) begin
      done_d = 1'b1;
      ohdl_d = '0;
      if (full) begin
        status_d = wsd_pkg::ST_FULL;
        notify_d = 1'b0;
      end else begin
        ram_we    = 1'b1;
        ram_wdata = {unst_q, hdl_q};
        if (req_q == wsd_pkg::REQ_PUSH_TAIL) begin
          ram_addr = tail_q;
          tail_d   = tail_p1;
        end else begin
          ram_addr = head_m1;
          head_d   = head_m1;
        end
        occ_d    = occ_q + 1'b1;
        status_d = wsd_pkg::ST_DONE;
        notify_d = nen_q;
      end
    end

    if (cmd_i.pop_rd) begin
      ram_addr = head_q;
    end

    if (cmd_i.pop_fin) begin
      ram_we   = 1'b1;
      ram_addr = head_q;
      head_d   = head_p1;
      occ_d    = occ_q - 1'b1;
      done_d   = 1'b1;
      ohdl_d   = rd_hdl;
      status_d = (rd_hdl != '0) ? wsd_pkg::ST_DONE : wsd_pkg::ST_NONE;
      notify_d = 1'b0;
    end

    if (cmd_i.empty_fin) begin
      done_d   = 1'b1;
      ohdl_d   = '0;
      status_d = wsd_pkg::ST_NONE;
      notify_d = 1'b0;
    end

    if (cmd_i.steal_start) begin
      scan_d = tail_m1;
      k_d    = OW'(1);
    end

    if (cmd_i.steal_rd) begin
      ram_addr = scan_q;
    end

    if (cmd_i.steal_chk) begin
      ram_addr = scan_q;
      if (hit) begin
        ram_we = 1'b1;
        if (k_q == OW'(1)) begin
          tail_d = scan_q;
          occ_d  = occ_q - 1'b1;
        end
        done_d   = 1'b1;
        ohdl_d   = rd_hdl;
        status_d = wsd_pkg::ST_DONE;
        notify_d = 1'b0;
      end else if (k_q == occ_q) begin
        done_d   = 1'b1;
        ohdl_d   = '0;
        status_d = wsd_pkg::ST_NONE;
        notify_d = 1'b0;
      end else begin
        scan_d = scan_m1;
        k_d    = k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= PW'(DEPTH / 2);
      tail_q <= PW'(DEPTH / 2);
      occ_q  <= '0;
      clr_q  <= '0;
      nen_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
      clr_q  <= clr_d;
      nen_q  <= nen_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    k_q      <= k_d;
    req_q    <= req_d;
    hdl_q    <= hdl_d;
    unst_q   <= unst_d;
    status_q <= status_d;
    ohdl_q   <= ohdl_d;
    notify_q <= notify_d;
  end

  assign sts_o.clr_last  = (clr_q == LAST);
  assign sts_o.occ_zero  = (occ_q == '0);
  assign sts_o.req       = req_q;
  assign sts_o.hit       = hit;
  assign sts_o.scan_last = (k_q == occ_q);

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_handle_o = ohdl_q;
  assign occupancy_o  = occ_q;
  assign notify_o     = notify_q;

endmodule

>>> rtl/work_steal_task_deque_unit.sv
// top level of the work-steal task deque: controller, datapath and checks
//
// channel   direction  transfer                  signals
// request   in         start && !busy            req_type_i, task_handle_i, task_unstealable_i
// result    out        done_o (one cycle)        status_o, out_handle_o, occupancy_o, notify_o
// config    in         cfg_we_i                  cfg_wdata_i (notify enable)
//
// push: captured in idle, written in exec; pop: read in exec, finished in pop_chk; empty pop or steal: ends in exec
// steal: steal_rd then steal_chk for each of k slots scanned back from the tail (one ram read and check each)
// a new request is taken in the cycle the result strobe is shown
// after reset the slot ram is cleared, every slot to zero, with busy high
// results cannot be held off; the strobe lasts exactly one cycle
module work_steal_task_deque_unit #(
  parameter int unsigned DEPTH       = wsd_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = wsd_pkg::HANDLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type_i,
  input  logic [HANDLE_BITS-1:0]     task_handle_i,
  input  logic                       task_unstealable_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [HANDLE_BITS-1:0]     out_handle_o,
  output logic [$clog2(DEPTH+1)-1:0] occupancy_o,
  output logic                       notify_o
);

  wsd_pkg::cmd_t cmd;
  wsd_pkg::sts_t sts;

  wsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  wsd_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_type_i         (req_type_i),
    .task_handle_i      (task_handle_i),
    .task_unstealable_i (task_unstealable_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .out_handle_o       (out_handle_o),
    .occupancy_o        (occupancy_o),
    .notify_o           (notify_o)
  );

  a_no_back_to_back_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe in two consecutive cycles");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request transfer not followed by busy");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == wsd_pkg::ST_FULL)) |-> (occupancy_o == ($clog2(DEPTH+1))'(DEPTH)))
    else $error("full status below depth");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= ($clog2(DEPTH+1))'(DEPTH)))
    else $error("occupancy above depth");

endmodule
